// ===== rtl/klle_pkg.sv =====
package klle_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND  = 3'd0,
    CMD_PREPEND = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_UPDATE  = 3'd4,
    CMD_DUMP    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NO_ANCHOR = 3'd2,
    ST_NO_KEY    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  localparam int unsigned MAX_RESULTS = 16;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction, start at head
    logic walk_start; // restart walk at head
    logic walk_step;  // follow link of current slot
    logic do_append;
    logic do_prepend;
    logic do_insert;
    logic do_delete;
    logic do_update;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic at_key;     // current slot holds key
    logic at_anchor;  // current slot holds anchor key
    logic at_end;     // current slot is last visited
  } dp_stat_t;

endpackage

// ===== rtl/klle_datapath.sv =====
module klle_datapath #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  klle_pkg::dp_cmd_t   cmd,
  output klle_pkg::dp_stat_t  stat,
  input  logic [31:0]         key_in,
  input  logic [31:0]         value_in,
  input  logic [31:0]         anchor_in,
  output logic [31:0]         cur_key,
  output logic [31:0]         cur_value
);
  localparam int unsigned SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned CW = $clog2(POOL_SLOTS + 1);

  logic [31:0]     keys   [POOL_SLOTS];
  logic [31:0]     values [POOL_SLOTS];
  logic [SW-1:0]   links  [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] is_end;
  logic [POOL_SLOTS-1:0] in_use;
  logic [SW-1:0]   head;
  logic [CW-1:0]   count;

  logic [31:0]     key_r, value_r, anchor_r;
  logic [SW-1:0]   cur, prev, anc;
  logic            prev_ok;
  logic [CW-1:0]   visited;
  logic [SW-1:0]   free_slot;

  always_comb begin
    free_slot = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) free_slot = SW'(i);
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count >= CW'(POOL_SLOTS));
  assign stat.at_key    = (keys[cur] == key_r);
  assign stat.at_anchor = (keys[cur] == anchor_r);
  assign stat.at_end    = is_end[cur] || (visited + CW'(1) >= count);
  assign cur_key   = keys[cur];
  assign cur_value = values[cur];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= key_in;
      value_r  <= value_in;
      anchor_r <= anchor_in;
    end
    if (cmd.load || cmd.walk_start) begin
      cur     <= head;
      prev_ok <= 1'b0;
      visited <= '0;
    end else if (cmd.walk_step) begin
      prev    <= cur;
      prev_ok <= 1'b1;
      cur     <= links[cur];
      visited <= visited + CW'(1);
    end
    // remember anchor slot found during walks
    if (cmd.walk_step || cmd.walk_start || cmd.load) begin
      if (stat.at_anchor) anc <= cur;
    end
    if (cmd.do_append || cmd.do_prepend || cmd.do_insert) begin
      keys[free_slot]   <= key_r;
      values[free_slot] <= value_r;
    end
    if (cmd.do_append) begin
      links[free_slot] <= '0;
      if (count != '0) links[cur] <= free_slot;
    end
    if (cmd.do_prepend) links[free_slot] <= head;
    if (cmd.do_insert) begin
      links[free_slot] <= links[anc];
      links[anc]       <= free_slot;
    end
    if (cmd.do_delete && prev_ok) links[prev] <= links[cur];
    if (cmd.do_update) values[cur] <= value_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      head   <= '0;
      count  <= '0;
      is_end <= '0;
    end else begin
      if (cmd.do_append) begin
        in_use[free_slot] <= 1'b1;
        is_end[free_slot] <= 1'b1;
        count <= count + CW'(1);
        if (count == '0) head <= free_slot;
        else is_end[cur] <= 1'b0;
      end
      if (cmd.do_prepend) begin
        in_use[free_slot] <= 1'b1;
        is_end[free_slot] <= (count == '0);
        count <= count + CW'(1);
        head  <= free_slot;
      end
      if (cmd.do_insert) begin
        in_use[free_slot] <= 1'b1;
        is_end[free_slot] <= is_end[anc];
        is_end[anc]       <= 1'b0;
        count <= count + CW'(1);
      end
      if (cmd.do_delete) begin
        in_use[cur] <= 1'b0;
        count <= count - CW'(1);
        if (prev_ok) is_end[prev] <= is_end[cur];
        else head <= is_end[cur] ? '0 : links[cur];
      end
    end
  end
endmodule

// ===== rtl/klle_ctrl.sv =====
module klle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_cmd,
  output klle_pkg::dp_cmd_t  cmd,
  input  klle_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic               out_dump,
  output logic               out_last
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WALK = 5'b00010,
    S_WALK2 = 5'b00100,
    S_DUMP = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [2:0] op, op_next;
  logic [2:0] status, status_next;
  logic found_anc, found_anc_next;
  logic [4:0] nout, nout_next;
  logic last_next, dump_next;
  logic out_valid_next;

  always_comb begin
    state_next = state;
    op_next = op;
    status_next = status;
    found_anc_next = found_anc;
    nout_next = nout;
    cmd = '0;
    in_ready = 1'b0;
    out_valid_next = out_valid;
    last_next = out_last;
    dump_next = out_dump;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !out_valid;
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          op_next = in_cmd;
          found_anc_next = 1'b0;
          nout_next = '0;
          case (in_cmd)
            klle_pkg::CMD_APPEND, klle_pkg::CMD_PREPEND, klle_pkg::CMD_INSERT,
            klle_pkg::CMD_DELETE, klle_pkg::CMD_UPDATE, klle_pkg::CMD_DUMP:
              state_next = S_WALK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        // scan list; for insert, look for anchor first
        if (op == klle_pkg::CMD_DUMP) begin
          if (stat.empty) begin
            status_next = klle_pkg::ST_EMPTY;
            state_next = S_OUT;
          end else state_next = S_DUMP;
        end else if (stat.empty) begin
          status_next = (op == klle_pkg::CMD_DELETE) ? klle_pkg::ST_EMPTY
                      : (op == klle_pkg::CMD_UPDATE) ? klle_pkg::ST_NO_KEY
                      : (op == klle_pkg::CMD_INSERT) ? klle_pkg::ST_NO_ANCHOR
                      : klle_pkg::ST_OK;
          if (op == klle_pkg::CMD_APPEND) cmd.do_append = 1'b1;
          if (op == klle_pkg::CMD_PREPEND) cmd.do_prepend = 1'b1;
          state_next = S_OUT;
        end else if (op == klle_pkg::CMD_INSERT && !found_anc) begin
          if (stat.at_anchor) begin
            found_anc_next = 1'b1;
            cmd.walk_start = 1'b1;
          end else if (stat.at_end) begin
            status_next = klle_pkg::ST_NO_ANCHOR;
            state_next = S_OUT;
          end else cmd.walk_step = 1'b1;
        end else if (stat.at_key) begin
          state_next = S_WALK2;
        end else if (stat.at_end) begin
          if (op == klle_pkg::CMD_DELETE || op == klle_pkg::CMD_UPDATE) begin
            status_next = klle_pkg::ST_NO_KEY;
          end else if (stat.full) begin
            status_next = klle_pkg::ST_FULL;
          end else begin
            status_next = klle_pkg::ST_OK;
            cmd.do_append  = (op == klle_pkg::CMD_APPEND);
            cmd.do_prepend = (op == klle_pkg::CMD_PREPEND);
            cmd.do_insert  = (op == klle_pkg::CMD_INSERT);
          end
          state_next = S_OUT;
        end else cmd.walk_step = 1'b1;
      end
      S_WALK2: begin
        // key found at current slot
        if (op == klle_pkg::CMD_DELETE) begin
          cmd.do_delete = 1'b1;
          status_next = klle_pkg::ST_OK;
        end else if (op == klle_pkg::CMD_UPDATE) begin
          cmd.do_update = 1'b1;
          status_next = klle_pkg::ST_OK;
        end else status_next = klle_pkg::ST_DUP;
        state_next = S_OUT;
      end
      S_DUMP: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          dump_next = 1'b1;
          last_next = stat.at_end || (nout == 5'(klle_pkg::MAX_RESULTS - 1));
          status_next = klle_pkg::ST_OK;
          nout_next = nout + 5'd1;
          if (last_next) state_next = S_IDLE;
          else cmd.walk_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          dump_next = 1'b0;
          last_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
    op <= op_next;
    found_anc <= found_anc_next;
    nout <= nout_next;
    out_last <= last_next;
    out_dump <= dump_next;
    if (state != S_DUMP || state_next != state || !out_valid || out_ready)
      status <= status_next;
  end
endmodule

// ===== rtl/keyed_linked_list_engine.sv =====
// channel  dir  handshake               payload
// s_axis   in   s_axis_tvalid/tready    tdata: command, key, value, anchor_key
// m_axis   out  m_axis_tvalid/tready    tdata: status, entry_key, entry_value; tlast
// One command at a time: a search walks one list slot per cycle (insert may walk
// twice); dump gives one result per cycle while the output is not stalled. Reset
// (rst, synchronous) empties the list. A stalled output holds the walk; the next
// command is taken once the last result has gone.
module keyed_linked_list_engine #(
  parameter int unsigned POOL_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // command[2:0], key, value, anchor_key
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // status[2:0], entry_key, entry_value, zeros
  output logic         m_axis_tlast
);
  klle_pkg::dp_cmd_t  cmd;
  klle_pkg::dp_stat_t stat;
  logic [31:0] cur_key, cur_value, ok_key, ok_value;
  logic [2:0]  status;
  logic        is_dump;

  klle_datapath #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .key_in(s_axis_tdata[34:3]), .value_in(s_axis_tdata[66:35]),
    .anchor_in(s_axis_tdata[98:67]),
    .cur_key, .cur_value
  );

  klle_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(s_axis_tdata[2:0]),
    .cmd, .stat,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(status), .out_dump(is_dump), .out_last(m_axis_tlast)
  );

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      ok_key   <= cur_key;
      ok_value <= cur_value;
    end
  end

  assign m_axis_tdata = {5'd0, is_dump ? ok_value : 32'd0,
                         is_dump ? ok_key : 32'd0, status};

`ifndef SYNTHESIS
  a_last_nondump: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !is_dump |-> m_axis_tlast) else $error("single result without last");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
`endif
endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  typedef struct {
    klle_pkg::status_t status;
    logic [31:0] ekey;
    logic [31:0] evalue;
    logic        last;
  } list_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tlast;

  keyed_linked_list_engine dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  // shadow copy of the list
  logic [31:0] sh_key [SLOTS];
  logic [31:0] sh_val [SLOTS];
  logic [3:0]  sh_next [SLOTS];
  logic        sh_end [SLOTS];
  logic [SLOTS-1:0] sh_used;
  int          sh_head;
  int          sh_count;

  list_result_t pending_results[$];
  int          errors = 0;
  int          cycle_count = 0;
  int          stall_mode = 0;
  logic        hold_off = 1'b0;
  bit          use_gaps = 1'b0;
  int          burst_left = 0;
  logic [31:0] key_set [24];

  // ---------------- predictor ----------------
  function automatic int find_slot(logic [31:0] k, output int prev);
    int s, p;
    s = sh_head;
    p = -1;
    prev = -1;
    for (int n = 0; n < sh_count; n++) begin
      if (sh_key[s] == k) begin
        prev = p;
        return s;
      end
      if (sh_end[s]) break;
      p = s;
      s = sh_next[s];
    end
    return -1;
  endfunction

  function automatic int take_slot(logic [31:0] k, logic [31:0] v);
    int s;
    s = 0;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (!sh_used[i]) s = i;
    sh_key[s] = k;
    sh_val[s] = v;
    sh_used[s] = 1'b1;
    sh_count++;
    return s;
  endfunction

  function automatic void push_status(klle_pkg::status_t st);
    list_result_t r;
    r.status = st;
    r.ekey = '0;
    r.evalue = '0;
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_list_op(logic [2:0] cmd, logic [31:0] k,
                                          logic [31:0] v, logic [31:0] anc);
    int s, a, p, t, n;
    bit full;
    bit fin;
    list_result_t r;
    full = (sh_count >= SLOTS);
    case (cmd)
      klle_pkg::CMD_APPEND, klle_pkg::CMD_PREPEND: begin
        if (find_slot(k, p) >= 0) push_status(klle_pkg::ST_DUP);
        else if (full) push_status(klle_pkg::ST_FULL);
        else begin
          if (cmd == klle_pkg::CMD_APPEND) begin
            if (sh_count == 0) begin
              s = take_slot(k, v);
              sh_head = s;
            end else begin
              t = sh_head;
              for (n = 1; n < sh_count && !sh_end[t]; n++) t = sh_next[t];
              s = take_slot(k, v);
              sh_next[t] = 4'(s);
              sh_end[t] = 1'b0;
            end
            sh_end[s] = 1'b1;
            sh_next[s] = '0;
          end else begin
            n = sh_count;
            s = take_slot(k, v);
            sh_next[s] = 4'(sh_head);
            sh_end[s] = (n == 0);
            sh_head = s;
          end
          push_status(klle_pkg::ST_OK);
        end
      end
      klle_pkg::CMD_INSERT: begin
        a = find_slot(anc, p);
        if (a < 0) push_status(klle_pkg::ST_NO_ANCHOR);
        else if (find_slot(k, p) >= 0) push_status(klle_pkg::ST_DUP);
        else if (full) push_status(klle_pkg::ST_FULL);
        else begin
          s = take_slot(k, v);
          sh_next[s] = sh_next[a];
          sh_end[s] = sh_end[a];
          sh_next[a] = 4'(s);
          sh_end[a] = 1'b0;
          push_status(klle_pkg::ST_OK);
        end
      end
      klle_pkg::CMD_DELETE: begin
        if (sh_count == 0) push_status(klle_pkg::ST_EMPTY);
        else begin
          s = find_slot(k, p);
          if (s < 0) push_status(klle_pkg::ST_NO_KEY);
          else begin
            if (p < 0) sh_head = sh_end[s] ? 0 : sh_next[s];
            else begin
              sh_next[p] = sh_next[s];
              sh_end[p] = sh_end[s];
            end
            sh_used[s] = 1'b0;
            sh_count--;
            push_status(klle_pkg::ST_OK);
          end
        end
      end
      klle_pkg::CMD_UPDATE: begin
        s = find_slot(k, p);
        if (s < 0) push_status(klle_pkg::ST_NO_KEY);
        else begin
          sh_val[s] = v;
          push_status(klle_pkg::ST_OK);
        end
      end
      klle_pkg::CMD_DUMP: begin
        if (sh_count == 0) push_status(klle_pkg::ST_EMPTY);
        else begin
          s = sh_head;
          for (n = 0; n < sh_count && n < klle_pkg::MAX_RESULTS; n++) begin
            fin = sh_end[s] || (n + 1 >= sh_count) || (n + 1 >= klle_pkg::MAX_RESULTS);
            r.status = klle_pkg::ST_OK;
            r.ekey = sh_key[s];
            r.evalue = sh_val[s];
            r.last = fin;
            pending_results.push_back(r);
            if (fin) break;
            s = sh_next[s];
          end
        end
      end
      default: ; // unused codes are dropped silently
    endcase
  endfunction

  // ---------------- driver ----------------
  task automatic send_cmd(logic [2:0] cmd, logic [31:0] k, logic [31:0] v,
                          logic [31:0] anc);
    int gap;
    bit taken;
    if (use_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, anc, v, k, cmd};
    // tready is stable between the falling and the next rising edge
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    predict_list_op(cmd, k, v, anc);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((cycle_count % 7) >= 2);
    endcase
  end

  // ---------------- checker ----------------
  always @(posedge clk) begin
    list_result_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d key=%h value=%h last=%b", $time,
                 m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[66:35], m_axis_tlast);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== e.status || m_axis_tdata[34:3] !== e.ekey ||
            m_axis_tdata[66:35] !== e.evalue || m_axis_tlast !== e.last) begin
          $display("%0t: mismatch expected status=%0d key=%h value=%h last=%b", $time,
                   e.status, e.ekey, e.evalue, e.last);
          $display("%0t:          actual   status=%0d key=%h value=%h last=%b", $time,
                   m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[66:35],
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_empty_list();
    send_cmd(klle_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
    send_cmd(klle_pkg::CMD_DELETE, 32'h1234, 32'h0, 32'h0);
    send_cmd(klle_pkg::CMD_UPDATE, 32'h1234, 32'h55, 32'h0);
    send_cmd(klle_pkg::CMD_INSERT, 32'h1, 32'h2, 32'h3);
    send_cmd(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_basic_ops();
    send_cmd(klle_pkg::CMD_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_cmd(klle_pkg::CMD_PREPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_cmd(klle_pkg::CMD_APPEND, 32'h8000_0000, 32'h1, 32'h0);         // duplicate
    send_cmd(klle_pkg::CMD_PREPEND, 32'h7FFF_FFFF, 32'h1, 32'h0);        // duplicate
    send_cmd(klle_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_cmd(klle_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000); // after tail
    send_cmd(klle_pkg::CMD_INSERT, 32'h0, 32'h9, 32'h8000_0000);         // duplicate
    send_cmd(klle_pkg::CMD_INSERT, 32'h0, 32'h9, 32'h5555_5555);         // no anchor
    send_cmd(klle_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
    send_cmd(klle_pkg::CMD_UPDATE, 32'h0, 32'hA5A5_5A5A, 32'h0);
    send_cmd(klle_pkg::CMD_UPDATE, 32'h42, 32'h1, 32'h0);
    send_cmd(klle_pkg::CMD_DELETE, 32'h42, 32'h0, 32'h0);
    send_cmd(klle_pkg::CMD_DELETE, 32'h7FFF_FFFF, 32'h0, 32'h0);         // head
    send_cmd(klle_pkg::CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 32'h0);         // tail
    send_cmd(3'd7, 32'h0, 32'h0, 32'h0);
    send_cmd(klle_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_pool_full();
    while (sh_count < SLOTS)
      send_cmd(3'($urandom_range(0, 1)), $urandom, $urandom, 32'h0);
    send_cmd(klle_pkg::CMD_APPEND, 32'h1357_9BDF, 32'h1, 32'h0);
    send_cmd(klle_pkg::CMD_PREPEND, 32'h1357_9BDF, 32'h1, 32'h0);
    send_cmd(klle_pkg::CMD_INSERT, 32'h1357_9BDF, 32'h1, 32'h8000_0000);
    send_cmd(klle_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
    while (sh_count > 0) send_cmd(klle_pkg::CMD_DELETE, sh_key[sh_head], 32'h0, 32'h0);
    send_cmd(klle_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic random_cmds(int count);
    int r, bias;
    logic [2:0] cmd;
    logic [31:0] k, anc;
    for (int i = 0; i < count; i++) begin
      bias = ((i / 40) % 2 == 0) ? 0 : 20;
      r = $urandom_range(0, 99);
      if (r < 18 - bias / 2) cmd = klle_pkg::CMD_APPEND;
      else if (r < 30 - bias / 2) cmd = klle_pkg::CMD_PREPEND;
      else if (r < 46) cmd = klle_pkg::CMD_INSERT;
      else if (r < 62 + bias) cmd = klle_pkg::CMD_DELETE;
      else if (r < 76 + bias / 2) cmd = klle_pkg::CMD_UPDATE;
      else if (r < 96) cmd = klle_pkg::CMD_DUMP;
      else cmd = 3'($urandom_range(6, 7));
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_set[$urandom_range(0, 23)];
      anc = ($urandom_range(0, 7) == 0) ? $urandom : key_set[$urandom_range(0, 23)];
      send_cmd(cmd, k, $urandom, anc);
    end
  endtask

  task automatic test_random();
    use_gaps = 1'b1;
    stall_mode = 1;
    random_cmds(60);
    stall_mode = 0;
    use_gaps = 1'b0;
    random_cmds(40);
    stall_mode = 2;
    use_gaps = 1'b1;
    random_cmds(50);
  endtask

  task automatic test_long_stall();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    stall_mode = 1;
    use_gaps = 1'b0;
    send_cmd(klle_pkg::CMD_DUMP, 32'h0, 32'h0, 32'h0);
    random_cmds(30);
  endtask

  initial begin
    for (int i = 0; i < 24; i++) key_set[i] = $urandom;
    key_set[0] = 32'h8000_0000;
    key_set[1] = 32'h7FFF_FFFF;
    key_set[2] = 32'h0;
    key_set[3] = 32'hFFFF_FFFF;
    sh_used = '0;
    sh_head = 0;
    sh_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    go_idle();
    test_pool_full();
    go_idle();
    test_random();
    test_long_stall();
    go_idle();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/klle_pkg.sv
rtl/klle_datapath.sv
rtl/klle_ctrl.sv
rtl/keyed_linked_list_engine.sv
tb/tb_top.sv
